### rtl/fpts_pkg.sv
// ----------------------------------------------------------------------------
// fpts_pkg
// Shared types and constants of the fixed-priority task scheduler: transfer
// payloads, operation and slot-state codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package fpts_pkg;

    localparam int MAX_SLOTS_DEF     = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    // operation codes
    localparam logic [2:0] OP_CONFIGURE = 3'd0;
    localparam logic [2:0] OP_ACTIVATE  = 3'd1;
    localparam logic [2:0] OP_CHAIN     = 3'd2;
    localparam logic [2:0] OP_TERMINATE = 3'd3;
    localparam logic [2:0] OP_START     = 3'd4;

    // slot state codes
    localparam logic [1:0] SLOT_SUSPENDED = 2'd0;
    localparam logic [1:0] SLOT_READY     = 2'd1;
    localparam logic [1:0] SLOT_RUNNING   = 2'd2;

    // configuration register index
    localparam int REG_TASK_COUNT = 0;

    typedef struct packed {
        logic [2:0] operation;
        logic [4:0] task_id;
        logic [7:0] task_priority;
        logic       start_ready;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [4:0] running_slot;
        logic       idle;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic apply_op;
        logic apply_id;
        logic scan_init;
        logic scan_step;
        logic commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       scan_done;
        logic       rsp_free;
    } status_t;

endpackage

### rtl/fixed_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// fixed_priority_task_scheduler
// Hardware fixed-priority task scheduler with an APB-style register port.
// ----------------------------------------------------------------------------
// One request transfer carries one operation (configure, activate, chain,
// terminate, start) and yields exactly one response transfer. Configure and
// the undefined operation codes skip the scan. Terminate and start scan
// min(task_count, MAX_SLOTS) slots, and activate and chain first apply the
// task id; the scan reads one slot per cycle through the single read port of
// the priority memory and then flushes its read pipeline. A new request is
// taken once the previous response sits in the output register, even while
// that response is still stalled. task_count is written through the register
// port at addresses 0 to 3 (paddr[2] clear). The user must write it only
// while the scheduler is idle; the block itself does not enforce this. No
// clearing pass runs after reset.
module fixed_priority_task_scheduler #(
    parameter int MAX_SLOTS     = fpts_pkg::MAX_SLOTS_DEF,
    parameter int PRIORITY_BITS = fpts_pkg::PRIORITY_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    // request channel
    input  logic           req_valid,
    output logic           req_stall,
    input  fpts_pkg::req_t req,
    // response channel
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fpts_pkg::rsp_t rsp,
    // register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [4:0]        task_count_reg;
    logic              reg_hit;
    fpts_pkg::cmd_t    cmd;
    fpts_pkg::status_t stat;

    assign reg_hit = (32'(paddr[2]) == fpts_pkg::REG_TASK_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            task_count_reg <= pwdata[4:0];
        end
    end

    assign prdata = reg_hit ? 32'(task_count_reg) : '0;

    fpts_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    fpts_datapath #(
        .MAX_SLOTS     (MAX_SLOTS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .task_count (task_count_reg),
        .cmd        (cmd),
        .rsp_stall  (rsp_stall),
        .stat       (stat),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

endmodule

### rtl/fpts_controller.sv
// ----------------------------------------------------------------------------
// fpts_controller
// Sequencer of one scheduler operation: state update steps, the slot scan,
// the commit of the winner and the hand-off to the response register.
// ----------------------------------------------------------------------------
module fpts_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  fpts_pkg::status_t stat,
    output fpts_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_APPLY_OP = 6'b000010,
        S_APPLY_ID = 6'b000100,
        S_SCAN     = 6'b001000,
        S_COMMIT   = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_APPLY_OP;
                end
            end
            S_APPLY_OP:
            begin
                cmd.apply_op = 1'b1;
                case (stat.op)
                    fpts_pkg::OP_ACTIVATE, fpts_pkg::OP_CHAIN:
                    begin
                        state_next = S_APPLY_ID;
                    end
                    fpts_pkg::OP_TERMINATE, fpts_pkg::OP_START:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        // configure and unknown codes do not reschedule
                        state_next = S_DONE;
                    end
                endcase
            end
            S_APPLY_ID:
            begin
                cmd.apply_id  = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

### rtl/fpts_datapath.sv
// ----------------------------------------------------------------------------
// fpts_datapath
// Slot table (state flops, priority memory), fill count, running slot,
// the one-slot-per-cycle priority scan and the response register.
// ----------------------------------------------------------------------------
module fpts_datapath #(
    parameter int MAX_SLOTS     = fpts_pkg::MAX_SLOTS_DEF,
    parameter int PRIORITY_BITS = fpts_pkg::PRIORITY_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpts_pkg::req_t    req,
    input  logic [4:0]        task_count,
    input  fpts_pkg::cmd_t    cmd,
    input  logic              rsp_stall,
    output fpts_pkg::status_t stat,
    output logic              rsp_valid,
    output fpts_pkg::rsp_t    rsp
);

    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int IW = $clog2(MAX_SLOTS);
    localparam int WW = ((SW > 5) ? SW : 5) + 1;
    localparam int PB = PRIORITY_BITS;

    // latched request
    logic [2:0]    op_reg;
    logic [4:0]    id_reg;
    logic [PB-1:0] prio_reg;
    logic          start_ready_reg;
    logic          status_reg;

    // slot table
    logic [1:0]    slot_state_reg [MAX_SLOTS];
    logic [PB-1:0] prio_mem [MAX_SLOTS];
    logic [SW-1:0] filled_reg;
    logic [SW-1:0] current_reg;

    // scan
    logic [WW-1:0] limit_reg;
    logic [WW-1:0] scan_reg;
    logic          pend_reg;
    logic [PB-1:0] rd_prio_reg;
    logic [1:0]    rd_state_reg;
    logic          rd_filled_reg;
    logic [WW-1:0] rd_slot_reg;
    logic [SW-1:0] best_reg;
    logic [PB-1:0] best_prio_reg;
    logic          found_reg;

    logic          rsp_valid_reg;
    fpts_pkg::rsp_t rsp_reg;
    fpts_pkg::rsp_t rsp_next;

    logic [PB+7:0] prio_ext;
    logic [PB-1:0] prio_in;
    logic          full;
    logic [IW-1:0] filled_idx;
    logic          id_ok;
    logic [WW-1:0] id_m1;
    logic          cur_ok;
    logic [SW-1:0] cur_m1;
    logic [SW-1:0] best_m1;
    logic [WW-1:0] scan_m1;
    logic [IW-1:0] scan_idx;
    logic          issue;
    logic [WW-1:0] tc_ext;
    logic [WW-1:0] limit_next;
    logic [PB-1:0] cand_prio;
    logic          cand_win;
    logic          mem_we;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [1:0]    wr_val;

    // only the low priority bits are kept
    assign prio_ext = {{PB{1'b0}}, req.task_priority};
    assign prio_in  = prio_ext[PB-1:0];

    assign full       = (filled_reg == SW'(MAX_SLOTS));
    assign filled_idx = filled_reg[IW-1:0];

    assign id_ok   = (WW'(id_reg) >= WW'(1)) && (WW'(id_reg) <= WW'(MAX_SLOTS));
    assign id_m1   = WW'(id_reg) - WW'(1);
    assign cur_ok  = (current_reg != '0);
    assign cur_m1  = current_reg - SW'(1);
    assign best_m1 = best_reg - SW'(1);

    assign scan_m1  = scan_reg - WW'(1);
    assign scan_idx = scan_m1[IW-1:0];
    assign issue    = cmd.scan_step && (scan_reg <= limit_reg);

    // task_count above the table size scans the whole table
    assign tc_ext     = WW'(task_count);
    assign limit_next = (tc_ext > WW'(MAX_SLOTS)) ? WW'(MAX_SLOTS) : tc_ext;

    // slots beyond the fill count were never written and are read as priority zero
    assign cand_prio = rd_filled_reg ? rd_prio_reg : '0;
    assign cand_win  = pend_reg && (rd_state_reg == fpts_pkg::SLOT_READY)
                       && (cand_prio >= best_prio_reg);

    assign mem_we = cmd.apply_op && (op_reg == fpts_pkg::OP_CONFIGURE) && !full;

    // one slot-state write per cycle
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = '0;
        wr_val = fpts_pkg::SLOT_SUSPENDED;
        if (cmd.apply_op)
        begin
            case (op_reg)
                fpts_pkg::OP_CONFIGURE:
                begin
                    wr_en  = !full;
                    wr_idx = filled_idx;
                    wr_val = start_ready_reg ? fpts_pkg::SLOT_READY
                                             : fpts_pkg::SLOT_SUSPENDED;
                end
                fpts_pkg::OP_ACTIVATE:
                begin
                    wr_en  = cur_ok;
                    wr_idx = cur_m1[IW-1:0];
                    wr_val = fpts_pkg::SLOT_READY;
                end
                fpts_pkg::OP_CHAIN, fpts_pkg::OP_TERMINATE:
                begin
                    wr_en  = cur_ok;
                    wr_idx = cur_m1[IW-1:0];
                    wr_val = fpts_pkg::SLOT_SUSPENDED;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.apply_id)
        begin
            wr_en  = id_ok;
            wr_idx = id_m1[IW-1:0];
            wr_val = fpts_pkg::SLOT_READY;
        end
        else if (cmd.commit)
        begin
            wr_en  = found_reg;
            wr_idx = best_m1[IW-1:0];
            wr_val = fpts_pkg::SLOT_RUNNING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                slot_state_reg[i] <= fpts_pkg::SLOT_SUSPENDED;
            end
        end
        else if (wr_en)
        begin
            slot_state_reg[wr_idx] <= wr_val;
        end
    end

    // priority memory, registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prio_mem[filled_idx] <= prio_reg;
        end
        if (issue)
        begin
            rd_prio_reg <= prio_mem[scan_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg          <= req.operation;
            id_reg          <= req.task_id;
            prio_reg        <= prio_in;
            start_ready_reg <= req.start_ready;
        end
        if (issue)
        begin
            rd_state_reg  <= slot_state_reg[scan_idx];
            rd_filled_reg <= (scan_m1 < WW'(filled_reg));
            rd_slot_reg   <= scan_reg;
        end
        if (cmd.scan_init)
        begin
            limit_reg <= limit_next;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= 1'b0;
            filled_reg    <= '0;
            current_reg   <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            best_reg      <= '0;
            best_prio_reg <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                status_reg <= 1'b0;
            end
            if (cmd.apply_op)
            begin
                if (op_reg == fpts_pkg::OP_CONFIGURE)
                begin
                    if (full)
                    begin
                        status_reg <= 1'b1;
                    end
                    else
                    begin
                        filled_reg <= filled_reg + SW'(1);
                    end
                end
                else if (op_reg == fpts_pkg::OP_START)
                begin
                    current_reg <= '0;
                end
            end
            if (cmd.scan_init)
            begin
                scan_reg      <= WW'(1);
                pend_reg      <= 1'b0;
                best_reg      <= '0;
                best_prio_reg <= '0;
                found_reg     <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    scan_reg <= scan_reg + WW'(1);
                end
                // ties go to the later slot
                if (cand_win)
                begin
                    best_reg      <= rd_slot_reg[SW-1:0];
                    best_prio_reg <= cand_prio;
                    found_reg     <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                current_reg <= found_reg ? best_reg : '0;
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        logic [WW-1:0] cur_ext;
        cur_ext               = WW'(current_reg);
        rsp_next.status       = status_reg;
        rsp_next.running_slot = cur_ext[4:0];
        rsp_next.idle         = (current_reg == '0);
    end

    assign stat.op        = op_reg;
    assign stat.scan_done = (scan_reg > limit_reg) && !pend_reg;
    assign stat.rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
